// ===== rtl/multiturn_angle_tracker_median5_defines.svh =====
// assertion macros for the multi-turn angle tracker
`ifndef MULTITURN_ANGLE_TRACKER_MEDIAN5_DEFINES_SVH
`define MULTITURN_ANGLE_TRACKER_MEDIAN5_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define MAT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define MAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MAT_ASSERT_NOW(lbl, ante, cons)
`define MAT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/mat_pkg.sv =====
package mat_pkg;

	localparam int ANGLE_BITS  = 12;
	localparam int DELTA_BITS  = 13;
	localparam int N_SAMPLES   = 5;
	localparam int OUT_BITS    = 32;
	localparam int HALF_TURN   = 2048;
	localparam int FULL_TURN   = 4096;

	// magnet status byte bits
	localparam logic [7:0] STAT_STRONG = 8'h08;
	localparam logic [7:0] STAT_WEAK   = 8'h10;
	localparam logic [7:0] STAT_OK     = 8'h20;

	typedef enum logic [1:0] {
		MAG_OK      = 2'd0,
		MAG_STRONG  = 2'd1,
		MAG_WEAK    = 2'd2,
		MAG_MISSING = 2'd3
	} mag_code_t;

	typedef enum logic {
		KIND_UPDATE    = 1'b0,
		KIND_CALIBRATE = 1'b1
	} kind_t;

	typedef logic [ANGLE_BITS-1:0] angle_t;

	typedef struct packed {
		logic         kind;
		angle_t       sample_a;
		angle_t       sample_b;
		angle_t       sample_c;
		angle_t       sample_d;
		angle_t       sample_e;
		logic [7:0]   magnet_status;
		logic         read_ok;
	} item_t;

	typedef struct packed {
		logic                       success;
		logic [1:0]                 magnet_code;
		logic signed [OUT_BITS-1:0] position_counts;
		logic signed [OUT_BITS-1:0] angle_counts;
	} result_t;

	// status byte decode, strong wins over weak, weak over ok
	function automatic mag_code_t decode_magnet(input logic [7:0] status);
		mag_code_t code;
		if ((status & STAT_STRONG) != 8'h00) begin
			code = MAG_STRONG;
		end else if ((status & STAT_WEAK) != 8'h00) begin
			code = MAG_WEAK;
		end else if ((status & STAT_OK) != 8'h00) begin
			code = MAG_OK;
		end else begin
			code = MAG_MISSING;
		end
		return code;
	endfunction

endpackage

// ===== rtl/mat_item_if.sv =====
interface mat_item_if;
	logic           valid;
	logic           ready;
	mat_pkg::item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mat_result_if.sv =====
interface mat_result_if;
	logic             valid;
	logic             ready;
	mat_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mat_median.sv =====
module mat_median #(
	parameter int WINDOW = 5
) (
	input  logic [mat_pkg::N_SAMPLES-1:0][mat_pkg::ANGLE_BITS-1:0] raw,
	input  logic [mat_pkg::ANGLE_BITS-1:0]                          last_angle,
	output logic signed [mat_pkg::DELTA_BITS-1:0]                   median
);

	localparam int RANK_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int MID       = WINDOW / 2;
	localparam int WIDE_BITS = mat_pkg::DELTA_BITS + 1;

	logic signed [mat_pkg::DELTA_BITS-1:0] delta [WINDOW];
	logic [RANK_BITS-1:0]                  rank  [WINDOW];

	// wrapped difference of each window sample, samples repeat every five
	always_comb begin
		logic signed [WIDE_BITS-1:0] d;
		for (int i = 0; i < WINDOW; i++) begin
			d = signed'({2'b00, raw[i % mat_pkg::N_SAMPLES]}) - signed'({2'b00, last_angle});
			if (d > WIDE_BITS'(mat_pkg::HALF_TURN)) begin
				d = d - WIDE_BITS'(mat_pkg::FULL_TURN);
			end else if (d < -WIDE_BITS'(mat_pkg::HALF_TURN)) begin
				d = d + WIDE_BITS'(mat_pkg::FULL_TURN);
			end
			delta[i] = d[mat_pkg::DELTA_BITS-1:0];
		end
	end

	// stable rank of each delta, ties broken by position
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if ((j != i) && ((delta[j] < delta[i]) || ((j < i) && (delta[j] == delta[i])))) begin
					rank[i] = rank[i] + 1'b1;
				end
			end
		end
	end

	// pick the delta whose rank is the middle one
	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (rank[i] == RANK_BITS'(MID)) begin
				median = median | delta[i];
			end
		end
	end

endmodule

// ===== rtl/multiturn_angle_tracker_median5.sv =====
// Multi-turn angle tracker for a 12-bit absolute angle sensor.
// Requests arrive on the items channel (valid/ready); each request gives one
// result on the results channel (valid/ready), in order.
// A calibrate request with a good read loads sample_a as the last angle and
// clears the position when the magnet status decodes as ok. Once calibrated, an
// update request with a good read unwraps five samples against the last angle,
// takes the median and adds it to the saturating position. Written via
// cfg_we/cfg_wdata, direction_negative negates the reported angle; the user
// must write it only while the block is idle, which the block does not enforce.
// Throughput: one request per cycle unless stalled; the median network, the
// saturating add and the state update all sit between the input stage and the
// result register, so the next request sees the updated state. When the
// receiver stalls, the result register holds its value and the input stage
// keeps one more request; ready drops once both are full.
// Reset clears the position, last angle, calibrated flag, direction and all
// valid flags; no result is pending after reset.
`include "multiturn_angle_tracker_median5_defines.svh"

module multiturn_angle_tracker_median5 #(
	parameter int WINDOW         = 5,
	parameter int POSITION_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	mat_item_if.sink            items,
	mat_result_if.source        results
);

	localparam int PW = POSITION_WIDTH;

	logic                             dir_neg_q;
	logic [mat_pkg::ANGLE_BITS-1:0]   last_angle_q;
	logic signed [PW-1:0]             position_q;
	logic                             is_cal_q;

	logic                             valid_s1;
	mat_pkg::item_t                   item_s1;
	logic                             valid_s2;
	mat_pkg::result_t                 result_s2;

	logic                             advance;
	logic signed [mat_pkg::DELTA_BITS-1:0] median;
	logic [mat_pkg::N_SAMPLES-1:0][mat_pkg::ANGLE_BITS-1:0] raw;

	mat_pkg::mag_code_t               code;
	logic                             cal_ok;
	logic                             upd_ok;
	logic signed [PW:0]               sum;
	logic signed [PW-1:0]             sat_pos;
	logic signed [PW-1:0]             next_pos;
	logic signed [PW-1:0]             dir_pos;
	logic [mat_pkg::ANGLE_BITS-1:0]   next_angle;

	localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance       = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready   = !valid_s1 || advance;
	assign results.valid = valid_s2;
	assign results.payload = result_s2;

	// median of the unwrapped window
	assign raw = {item_s1.sample_e, item_s1.sample_d, item_s1.sample_c,
		item_s1.sample_b, item_s1.sample_a};

	mat_median #(
		.WINDOW(WINDOW)
	) u_median (
		.raw       (raw),
		.last_angle(last_angle_q),
		.median    (median)
	);

	// decode and state update
	always_comb begin
		code   = mat_pkg::MAG_OK;
		cal_ok = 1'b0;
		upd_ok = 1'b0;
		if (item_s1.kind == mat_pkg::KIND_CALIBRATE) begin
			if (item_s1.read_ok) begin
				code   = mat_pkg::decode_magnet(item_s1.magnet_status);
				cal_ok = (code == mat_pkg::MAG_OK);
			end
		end else begin
			upd_ok = is_cal_q && item_s1.read_ok;
		end
	end

	// saturating add of the median, overflow shows in the top two bits
	always_comb begin
		sum = (PW + 1)'(position_q) + (PW + 1)'(median);
		if (sum[PW] != sum[PW-1]) begin
			sat_pos = sum[PW] ? POS_MIN : POS_MAX;
		end else begin
			sat_pos = sum[PW-1:0];
		end
	end

	assign next_angle = last_angle_q + median[mat_pkg::ANGLE_BITS-1:0];

	always_comb begin
		if (cal_ok) begin
			next_pos = '0;
		end else if (upd_ok) begin
			next_pos = sat_pos;
		end else begin
			next_pos = position_q;
		end
	end

	// direction applied, most negative clamps to most positive
	always_comb begin
		if (!dir_neg_q) begin
			dir_pos = next_pos;
		end else if (next_pos == POS_MIN) begin
			dir_pos = POS_MAX;
		end else begin
			dir_pos = -next_pos;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_neg_q <= 1'b0;
		end else if (cfg_we) begin
			dir_neg_q <= cfg_wdata;
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
			position_q   <= '0;
			is_cal_q     <= 1'b0;
		end else if (advance) begin
			position_q <= next_pos;
			if (cal_ok) begin
				last_angle_q <= item_s1.sample_a;
				is_cal_q     <= 1'b1;
			end else if (upd_ok) begin
				last_angle_q <= next_angle;
			end
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.payload;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.success         <= cal_ok || upd_ok;
			result_s2.magnet_code     <= code;
			result_s2.position_counts <= mat_pkg::OUT_BITS'(next_pos);
			result_s2.angle_counts    <= mat_pkg::OUT_BITS'(dir_pos);
		end
	end

	// checks
	`MAT_ASSERT_NEXT(a_state_holds, !advance, $stable(position_q) && $stable(last_angle_q))
	`MAT_ASSERT_NOW(a_no_overrun, valid_s2 && !results.ready, !advance)
	`MAT_ASSERT_NEXT(a_cal_clears, advance && cal_ok, position_q == '0 && is_cal_q)
	`MAT_ASSERT_NOW(a_fail_code, results.valid && results.payload.magnet_code != mat_pkg::MAG_OK, !results.payload.success)

endmodule

// ===== dv/mat_tracker_checker.sv =====
`timescale 1ns / 1ps

// watches both channels, tracks the multi-turn position and checks every result
module mat_tracker_checker (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_wdata,
	mat_item_if   items,
	mat_result_if results,
	output int    errors,
	output int    pending
);

	import mat_pkg::*;

	localparam logic signed [OUT_BITS-1:0] POS_TOP    = 32'sh7fffffff;
	localparam logic signed [OUT_BITS-1:0] POS_BOTTOM = 32'sh80000000;

	// tracked copy of the block state
	logic                       neg_dir;
	angle_t                     last_ang;
	logic signed [OUT_BITS-1:0] pos;
	logic                       calibrated;
	result_t                    awaited_results[$];

	// status byte priority: strong, then weak, then ok
	function automatic mag_code_t magnet_of(input logic [7:0] st);
		if ((st & STAT_STRONG) != 8'h00) return MAG_STRONG;
		if ((st & STAT_WEAK) != 8'h00) return MAG_WEAK;
		if ((st & STAT_OK) != 8'h00) return MAG_OK;
		return MAG_MISSING;
	endfunction

	// shortest signed step from one angle to another, half turn kept as is
	function automatic int unwrap(input angle_t raw, input angle_t from);
		int d;
		d = int'(raw) - int'(from);
		if (d > HALF_TURN) begin
			d -= FULL_TURN;
		end else if (d < -HALF_TURN) begin
			d += FULL_TURN;
		end
		return d;
	endfunction

	// median of the five unwrapped steps
	function automatic int median_step(input item_t it, input angle_t from);
		int v[N_SAMPLES];
		int t;
		int i;
		int j;
		v[0] = unwrap(it.sample_a, from);
		v[1] = unwrap(it.sample_b, from);
		v[2] = unwrap(it.sample_c, from);
		v[3] = unwrap(it.sample_d, from);
		v[4] = unwrap(it.sample_e, from);
		for (i = 0; i < N_SAMPLES - 1; i++) begin
			for (j = 0; j < N_SAMPLES - 1 - i; j++) begin
				if (v[j] > v[j+1]) begin
					t = v[j];
					v[j] = v[j+1];
					v[j+1] = t;
				end
			end
		end
		return v[N_SAMPLES/2];
	endfunction

	// apply one request to the tracked state and queue its result
	task automatic track_request(input item_t it);
		result_t r;
		int      m;
		longint  sum;
		r.success     = 1'b0;
		r.magnet_code = MAG_OK;
		if (it.kind == KIND_CALIBRATE) begin
			if (it.read_ok) begin
				r.magnet_code = magnet_of(it.magnet_status);
				if (r.magnet_code == MAG_OK) begin
					last_ang   = it.sample_a;
					pos        = '0;
					calibrated = 1'b1;
					r.success  = 1'b1;
				end
			end
		end else if (calibrated && it.read_ok) begin
			m   = median_step(it, last_ang);
			sum = longint'(pos) + longint'(m);
			if (sum > longint'(POS_TOP)) begin
				pos = POS_TOP;
			end else if (sum < longint'(POS_BOTTOM)) begin
				pos = POS_BOTTOM;
			end else begin
				pos = sum[OUT_BITS-1:0];
			end
			last_ang  = last_ang + m[ANGLE_BITS-1:0];
			r.success = 1'b1;
		end
		r.position_counts = pos;
		if (!neg_dir) begin
			r.angle_counts = pos;
		end else if (pos == POS_BOTTOM) begin
			r.angle_counts = POS_TOP;
		end else begin
			r.angle_counts = -pos;
		end
		awaited_results.push_back(r);
	endtask

	// compare one delivered result with the oldest awaited one
	task automatic check_result(input result_t got);
		result_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result success=%0d code=%0d position=%0d angle=%0d",
				$time, got.success, got.magnet_code, got.position_counts, got.angle_counts);
			errors++;
		end else begin
			want = awaited_results.pop_front();
			if (got.success !== want.success || got.magnet_code !== want.magnet_code ||
				got.position_counts !== want.position_counts ||
				got.angle_counts !== want.angle_counts) begin
				$display("%0t: expected success=%0d code=%0d position=%0d angle=%0d",
					$time, want.success, want.magnet_code, want.position_counts,
					want.angle_counts);
				$display("%0t:   actual success=%0d code=%0d position=%0d angle=%0d",
					$time, got.success, got.magnet_code, got.position_counts,
					got.angle_counts);
				errors++;
			end
		end
	endtask

	// sample handshakes and the register write at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_dir    = 1'b0;
			last_ang   = '0;
			pos        = '0;
			calibrated = 1'b0;
			awaited_results.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			if (results.valid && results.ready) check_result(results.payload);
			if (cfg_we) neg_dir = cfg_wdata;
			if (items.valid && items.ready) track_request(items.payload);
			pending = awaited_results.size();
		end
	end

endmodule

// ===== dv/tb_multiturn_angle_tracker_median5.sv =====
`timescale 1ns / 1ps

module tb_multiturn_angle_tracker_median5;

	import mat_pkg::*;

	localparam int     DRAIN_CYCLES   = 10;
	localparam int     LONG_STALL     = 300;
	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     DOWN_STEP      = 2047;
	localparam int     SWEEP_STEPS    = 24;
	localparam int     PHASE_ITEMS    = 520;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_wdata;
	logic stall_kick;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;
	int sent_count   = 0;
	int errors;
	int pending;

	mat_item_if   items_ch ();
	mat_result_if results_ch ();

	multiturn_angle_tracker_median5 DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (items_ch),
		.results  (results_ch)
	);

	mat_tracker_checker u_tracker_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (items_ch),
		.results  (results_ch),
		.errors   (errors),
		.pending  (pending)
	);

	always #10 clk = ~clk;

	// receiver: random back-pressure plus a long hold-off when stall_kick is raised
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (stall_kick) stall_left = LONG_STALL;
			if (stall_left > 0) begin
				stall_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("multiturn_angle_tracker_median5: mismatch");
					$finish;
				end
			end
		end
	end

	// present one request and hold it until accepted
	task automatic offer(input item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid   <= 1'b1;
		items_ch.payload <= it;
		do @(posedge clk); while (items_ch.ready !== 1'b1);
		sent_count++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// direction register, written only with the block idle
	task automatic write_direction(input logic neg);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= neg;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic item_t calib_req(input angle_t a, input logic [7:0] st, input logic ok);
		item_t it;
		it.kind          = KIND_CALIBRATE;
		it.sample_a      = a;
		it.sample_b      = angle_t'($urandom);
		it.sample_c      = angle_t'($urandom);
		it.sample_d      = angle_t'($urandom);
		it.sample_e      = angle_t'($urandom);
		it.magnet_status = st;
		it.read_ok       = ok;
		return it;
	endfunction

	function automatic item_t update_req(input angle_t a, input angle_t b, input angle_t c,
		input angle_t d, input angle_t e, input logic ok);
		item_t it;
		it.kind          = KIND_UPDATE;
		it.sample_a      = a;
		it.sample_b      = b;
		it.sample_c      = c;
		it.sample_d      = d;
		it.sample_e      = e;
		it.magnet_status = 8'($urandom);
		it.read_ok       = ok;
		return it;
	endfunction

	// clustered windows with outliers, mostly updates, mostly good reads
	function automatic item_t random_req();
		angle_t     s[N_SAMPLES];
		int         center;
		int         shape;
		int         i;
		logic [7:0] st;
		logic       ok;
		center = $urandom_range(FULL_TURN - 1);
		shape  = $urandom_range(99);
		for (i = 0; i < N_SAMPLES; i++) begin
			if (shape < 10) begin
				s[i] = angle_t'($urandom);
			end else begin
				s[i] = angle_t'(center + int'($urandom_range(64)) - 32);
			end
		end
		if (shape >= 10 && shape < 40) s[$urandom_range(N_SAMPLES - 1)] = angle_t'($urandom);
		if (shape >= 10 && shape < 25) s[$urandom_range(N_SAMPLES - 1)] = angle_t'($urandom);
		st = 8'($urandom);
		if ($urandom_range(99) < 70) st = (st & ~(STAT_STRONG | STAT_WEAK)) | STAT_OK;
		ok = ($urandom_range(99) < 90);
		if ($urandom_range(99) < 8) return calib_req(s[0], st, ok);
		return update_req(s[0], s[1], s[2], s[3], s[4], ok);
	endfunction

	// one random stretch, with a full drain halfway through
	task automatic random_phase(input int count, input int src_pct, input int snk_pct);
		int i;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		offer(calib_req(angle_t'($urandom), STAT_OK, 1'b1));
		for (i = 0; i < count; i++) begin
			offer(random_req());
			if (i == count / 2) wait_drained();
		end
	endtask

	// constant downward steps of just under a half turn
	task automatic floor_sweep();
		angle_t at;
		int     n;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		at = '0;
		offer(calib_req(at, STAT_OK, 1'b1));
		for (n = 0; n < SWEEP_STEPS; n++) begin
			at = at - DOWN_STEP[ANGLE_BITS-1:0];
			offer(update_req(at, at, at, at, at, 1'b1));
		end
		// descent seen with both directions, then one half turn back up
		write_direction(1'b0);
		offer(update_req(at, at, at, at, at, 1'b0));
		write_direction(1'b1);
		offer(update_req(at, at, at, at, at, 1'b0));
		at = at + HALF_TURN[ANGLE_BITS-1:0];
		offer(update_req(at, at, at, at, at, 1'b1));
	endtask

	initial begin
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		stall_kick         = 1'b0;
		items_ch.valid     = 1'b0;
		items_ch.payload   = '0;
		results_ch.ready   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// status decode and unwrap edges, sensor direction kept
		write_direction(1'b0);
		offer(update_req(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2048, 1'b1));
		offer(calib_req(12'd100, STAT_OK, 1'b0));
		offer(calib_req(12'd100, 8'h00, 1'b1));
		offer(calib_req(12'd100, 8'hff, 1'b1));
		offer(calib_req(12'd100, 8'h30, 1'b1));
		offer(calib_req(12'd100, 8'hf7, 1'b1));
		offer(calib_req(12'd0, 8'he7, 1'b1));
		offer(update_req(12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 1'b0));
		offer(update_req(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1));
		offer(update_req(12'd2047, 12'd2047, 12'd2047, 12'd2047, 12'd2047, 1'b1));
		offer(update_req(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1));
		offer(update_req(12'd0, 12'd4095, 12'd4094, 12'd100, 12'd3000, 1'b1));
		offer(calib_req(12'd4095, STAT_OK, 1'b1));
		offer(update_req(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1));
		offer(calib_req(12'd7, 8'h7f, 1'b1));
		offer(calib_req(12'd7, 8'hc0, 1'b1));
		offer(update_req(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2048, 1'b1));

		// negated direction
		write_direction(1'b1);
		offer(update_req(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1));
		offer(update_req(12'd9, 12'd9, 12'd9, 12'd9, 12'd9, 1'b0));

		random_phase(PHASE_ITEMS, 15, 82);
		write_direction(1'b0);
		random_phase(PHASE_ITEMS, 82, 15);
		write_direction(1'b1);
		random_phase(PHASE_ITEMS, 0, 0);

		// long receiver hold-off while requests keep coming
		stall_kick <= 1'b1;
		@(posedge clk);
		stall_kick <= 1'b0;
		repeat (40) offer(random_req());

		floor_sweep();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d requests: decode and unwrap edges, three stall mixes, both directions",
			sent_count);
		$display("including a %0d-step descent at just under a half turn per request",
			SWEEP_STEPS);
		if (errors == 0 && pending == 0) begin
			$display("multiturn_angle_tracker_median5: match");
		end else begin
			$display("multiturn_angle_tracker_median5: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mat_pkg.sv
rtl/mat_item_if.sv
rtl/mat_result_if.sv
rtl/mat_median.sv
rtl/multiturn_angle_tracker_median5.sv
dv/mat_tracker_checker.sv
dv/tb_multiturn_angle_tracker_median5.sv
